[design/smt_pkg.sv]
// ----------------------------------------------------------------------------
// smt_pkg
// Shared constants, types and index helpers of the transfer sequencer.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    localparam logic [7:0] SLAVE_ID     = 8'h20;
    localparam logic [7:0] PRESENCE_LOC = 8'hAB;
    localparam logic [7:0] DIR_MASK     = 8'hFE;

    // operations
    localparam logic [2:0] OP_TX_WRITE = 3'd0;
    localparam logic [2:0] OP_RX_READ  = 3'd1;
    localparam logic [2:0] OP_BEGIN    = 3'd2;
    localparam logic [2:0] OP_EVENT    = 3'd3;
    localparam logic [2:0] OP_TIMEOUT  = 3'd4;

    // bus engine status codes
    localparam logic [4:0] ST_START      = 5'd1;
    localparam logic [4:0] ST_RSTART     = 5'd2;
    localparam logic [4:0] ST_ADDR_ACK   = 5'd3;
    localparam logic [4:0] ST_ADDR_NACK  = 5'd4;
    localparam logic [4:0] ST_DATA_ACK   = 5'd5;
    localparam logic [4:0] ST_DATA_NACK  = 5'd6;
    localparam logic [4:0] ST_RADDR_ACK  = 5'd8;
    localparam logic [4:0] ST_RADDR_NACK = 5'd9;
    localparam logic [4:0] ST_RDATA_ACK  = 5'd10;
    localparam logic [4:0] ST_RDATA_NACK = 5'd11;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET   = 3'd0;
    localparam logic [2:0] CFG_LOCATION = 3'd1;
    localparam logic [2:0] CFG_COUNT    = 3'd2;
    localparam logic [2:0] CFG_READ     = 3'd3;
    localparam logic [2:0] CFG_RETRY    = 3'd4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef t_addr t_wrap_tbl [256];

    typedef struct packed {
        logic       tx_we;
        t_addr      tx_waddr;
        logic [7:0] tx_wdata;
        t_addr      tx_raddr;
        logic       rx_we;
        t_addr      rx_waddr;
        logic [7:0] rx_wdata;
        t_addr      rx_raddr;
    } t_mem_req;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_byte_valid;
        logic       tx_from_mem;
        logic       rd_from_mem;
        logic       start_request;
        logic       stop_request;
        logic       ack_enable;
        logic       bus_busy;
        logic       write_done;
        logic       read_done;
        logic       no_response;
        logic       engine_reset;
    } t_result;

    function automatic t_wrap_tbl build_wrap();
        t_wrap_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = ADDR_W'(i % BUFFER_DEPTH);
        end
        return tbl;
    endfunction

    // byte value modulo the buffer depth
    localparam t_wrap_tbl WRAP_TBL = build_wrap();

    // sum of two reduced indexes, wrapped once
    function automatic t_addr wrap_add(t_addr a, t_addr b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W+1)'(BUFFER_DEPTH)) begin
            s = s - (ADDR_W+1)'(BUFFER_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

[design/smt_buf.sv]
// ----------------------------------------------------------------------------
// smt_buf
// Transmit and receive byte stores, one write and one registered read each.
// ----------------------------------------------------------------------------
module smt_buf
    import smt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rd_en,
    input  t_mem_req   i_req,
    output logic [7:0] o_tx_q,
    output logic [7:0] o_rx_q
);

    logic [7:0] r_tx_mem [BUFFER_DEPTH];
    logic [7:0] r_rx_mem [BUFFER_DEPTH];
    logic [7:0] r_tx_q;
    logic [7:0] r_rx_q;

    always_ff @(posedge i_clk) begin
        if (i_req.tx_we) begin
            r_tx_mem[i_req.tx_waddr] <= i_req.tx_wdata;
        end
        if (i_rd_en) begin
            r_tx_q <= r_tx_mem[i_req.tx_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rx_we) begin
            r_rx_mem[i_req.rx_waddr] <= i_req.rx_wdata;
        end
        if (i_rd_en) begin
            r_rx_q <= r_rx_mem[i_req.rx_raddr];
        end
    end

    assign o_tx_q = r_tx_q;
    assign o_rx_q = r_rx_q;

endmodule

[design/smt_ctrl.sv]
// ----------------------------------------------------------------------------
// smt_ctrl
// Configuration registers, transfer flags and counters; decodes each word
// into store accesses and the flag part of its result.
// ----------------------------------------------------------------------------
module smt_ctrl
    import smt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_accept,
    input  logic [2:0] i_operation,
    input  logic [6:0] i_buf_index,
    input  logic [7:0] i_buf_data,
    input  logic [4:0] i_status_code,
    input  logic [7:0] i_rx_byte,
    output t_mem_req   o_req,
    output t_result    o_res
);

    logic [7:0] r_target, r_loc, r_count, r_retry_lim;
    logic       r_read_mode;
    logic [7:0] r_sent, n_sent;
    logic [7:0] r_recv, n_recv;
    logic [7:0] r_nacks, n_nacks;
    logic       r_busy, n_busy;
    logic       r_start, n_start;
    logic       r_ack, n_ack;
    logic [1:0] r_done, n_done;
    logic       r_silent, n_silent;

    logic       w_mine;
    logic       w_fail;
    t_addr      w_loc_w;
    t_mem_req   w_req;
    t_result    w_res;

    assign w_mine  = (r_target == SLAVE_ID);
    assign w_loc_w = WRAP_TBL[r_loc];

    always_comb begin
        n_sent   = r_sent;
        n_recv   = r_recv;
        n_nacks  = r_nacks;
        n_busy   = r_busy;
        n_start  = r_start;
        n_ack    = r_ack;
        n_done   = r_done;
        n_silent = r_silent;
        w_fail   = 1'b0;
        w_res    = '0;

        w_req.tx_we    = 1'b0;
        w_req.tx_waddr = WRAP_TBL[{1'b0, i_buf_index}];
        w_req.tx_wdata = i_buf_data;
        w_req.tx_raddr = wrap_add(w_loc_w, WRAP_TBL[r_sent]);
        w_req.rx_we    = 1'b0;
        w_req.rx_waddr = wrap_add(w_loc_w, WRAP_TBL[r_recv]);
        w_req.rx_wdata = i_rx_byte;
        w_req.rx_raddr = WRAP_TBL[{1'b0, i_buf_index}];

        unique case (i_operation)
            OP_TX_WRITE: w_req.tx_we = 1'b1;
            OP_RX_READ:  w_res.rd_from_mem = 1'b1;
            OP_BEGIN: begin
                n_busy  = 1'b1;
                n_start = 1'b1;
            end
            OP_TIMEOUT: w_fail = 1'b1;
            OP_EVENT: begin
                unique case (i_status_code)
                    ST_START, ST_RSTART: begin
                        w_res.tx_byte       = (r_target & DIR_MASK) | {7'd0, r_read_mode};
                        w_res.tx_byte_valid = 1'b1;
                        n_start             = 1'b0;
                        n_sent              = '0;
                        n_recv              = '0;
                    end
                    ST_ADDR_ACK: begin
                        if (w_mine) begin
                            if (r_loc == PRESENCE_LOC) begin
                                w_res.stop_request = 1'b1;
                                n_busy             = 1'b0;
                            end else begin
                                w_res.tx_byte       = r_loc;
                                w_res.tx_byte_valid = 1'b1;
                                n_done[0]           = 1'b0;
                            end
                            n_silent = 1'b0;
                        end
                    end
                    ST_ADDR_NACK, ST_DATA_NACK, ST_RADDR_NACK: begin
                        if (w_mine) begin
                            if (r_nacks < r_retry_lim) begin
                                n_nacks = r_nacks + 8'd1;
                                n_start = 1'b1;
                            end else begin
                                n_silent = 1'b1;
                                n_nacks  = '0;
                                w_fail   = 1'b1;
                            end
                        end
                    end
                    ST_DATA_ACK: begin
                        if (w_mine) begin
                            if (r_sent < r_count) begin
                                w_res.tx_from_mem   = 1'b1;
                                w_res.tx_byte_valid = 1'b1;
                                n_sent              = r_sent + 8'd1;
                            end else begin
                                w_res.stop_request = 1'b1;
                                n_busy             = 1'b0;
                                n_done[0]          = 1'b1;
                            end
                        end
                    end
                    ST_RADDR_ACK: n_ack = (r_count != 8'd1);
                    ST_RDATA_ACK: begin
                        if (w_mine) begin
                            if (r_recv < r_count) begin
                                w_req.rx_we = 1'b1;
                                n_ack       = 1'b1;
                                n_recv      = r_recv + 8'd1;
                                n_done[1]   = 1'b0;
                            end else begin
                                n_ack     = 1'b0;
                                n_done[1] = 1'b1;
                            end
                        end
                    end
                    ST_RDATA_NACK: begin
                        if (w_mine) begin
                            w_req.rx_we        = 1'b1;
                            w_res.stop_request = 1'b1;
                            n_busy             = 1'b0;
                            n_ack              = 1'b1;
                            n_done[1]          = 1'b1;
                        end
                    end
                    // no status, arbitration lost and unknown codes
                    default: w_fail = 1'b1;
                endcase
            end
            default: ;
        endcase

        if (w_fail) begin
            w_res.engine_reset = 1'b1;
            w_res.stop_request = 1'b0;
            n_start            = 1'b0;
            n_ack              = 1'b0;
            n_busy             = 1'b0;
            n_done             = 2'b11;
        end

        w_res.start_request = n_start;
        w_res.ack_enable    = n_ack;
        w_res.bus_busy      = n_busy;
        w_res.write_done    = n_done[0];
        w_res.read_done     = n_done[1];
        w_res.no_response   = n_silent;

        w_req.tx_we = w_req.tx_we & i_accept;
        w_req.rx_we = w_req.rx_we & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 8'h20;
            r_loc       <= '0;
            r_count     <= '0;
            r_read_mode <= 1'b0;
            r_retry_lim <= 8'd3;
            r_sent      <= '0;
            r_recv      <= '0;
            r_nacks     <= '0;
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_ack       <= 1'b1;
            r_done      <= '0;
            r_silent    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TARGET:   r_target    <= i_cfg_data;
                    CFG_LOCATION: r_loc       <= i_cfg_data;
                    CFG_COUNT:    r_count     <= i_cfg_data;
                    CFG_READ:     r_read_mode <= i_cfg_data[0];
                    CFG_RETRY:    r_retry_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_sent   <= n_sent;
                r_recv   <= n_recv;
                r_nacks  <= n_nacks;
                r_busy   <= n_busy;
                r_start  <= n_start;
                r_ack    <= n_ack;
                r_done   <= n_done;
                r_silent <= n_silent;
            end
        end
    end

    assign o_req = w_req;
    assign o_res = w_res;

    a_fail_releases_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_res.engine_reset |->
            !w_res.bus_busy && w_res.write_done && w_res.read_done && !w_res.start_request)
        else $error("engine reset without releasing the bus");

    a_rx_write_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.rx_we |-> i_accept && w_mine && (i_operation == OP_EVENT))
        else $error("receive store written outside a data event");

    a_sent_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (n_sent != r_sent) |-> (n_sent == r_sent + 8'd1) || (n_sent == 8'd0))
        else $error("sent counter moved by more than one");

endmodule

[design/smt_pipe.sv]
// ----------------------------------------------------------------------------
// smt_pipe
// Store-read stage and output register; merges store data into the result.
// ----------------------------------------------------------------------------
module smt_pipe
    import smt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_result    i_res,
    input  logic [7:0] i_tx_q,
    input  logic [7:0] i_rx_q,
    input  logic       i_out_stall,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_result    o_res,
    output logic [7:0] o_read_data
);

    logic       r_s1_valid;
    t_result    r_s1_res;
    t_result    w_s1_res;
    logic       r_out_valid;
    t_result    r_out_res;
    logic [7:0] r_out_rdata;
    logic       w_move;

    // read stage advances whenever the output register is free or draining
    assign w_move     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_move;

    // transmit byte comes from the store for a data ack
    always_comb begin
        w_s1_res = r_s1_res;
        if (r_s1_res.tx_from_mem) begin
            w_s1_res.tx_byte = i_tx_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_res <= i_res;
        end
        if (w_move) begin
            r_out_res   <= w_s1_res;
            r_out_rdata <= r_s1_res.rd_from_mem ? i_rx_q : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out_res;
    assign o_read_data = r_out_rdata;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_s1_valid)
        else $error("accepted word lost before the read stage");

    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("word lost between read stage and output");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_move |-> !i_accept)
        else $error("word accepted over a held read stage");

endmodule

[design/smbus_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// smbus_master_transfer_sequencer
// Sequences one SMBus/I2C master transfer from byte-engine status events.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word, which passes two registers
// after it is accepted: the synchronous read of the transmit or receive store
// and the output register. A new word may be accepted every cycle while the
// read stage can drain, and one more is taken while a finished result waits
// on a stalled output. Flags and counters update at the accept edge, so the
// store read of the next word already sees them. The stores come up
// undefined; there is no clearing pass after reset.
module smbus_master_transfer_sequencer
    import smt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic [6:0] i_buf_index,
    input  logic [7:0] i_buf_data,
    input  logic [4:0] i_status_code,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_byte_valid,
    output logic       o_start_request,
    output logic       o_stop_request,
    output logic       o_ack_enable,
    output logic       o_bus_busy,
    output logic       o_write_done,
    output logic       o_read_done,
    output logic       o_no_response,
    output logic       o_engine_reset,
    output logic [7:0] o_read_data
);

    logic       w_accept;
    t_mem_req   w_req;
    t_result    w_res;
    t_result    w_out_res;
    logic [7:0] w_tx_q;
    logic [7:0] w_rx_q;

    assign w_accept = i_in_valid && !o_in_stall;

    smt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (w_accept),
        .i_operation   (i_operation),
        .i_buf_index   (i_buf_index),
        .i_buf_data    (i_buf_data),
        .i_status_code (i_status_code),
        .i_rx_byte     (i_rx_byte),
        .o_req         (w_req),
        .o_res         (w_res)
    );

    smt_buf u_buf (
        .i_clk   (i_clk),
        .i_rd_en (w_accept),
        .i_req   (w_req),
        .o_tx_q  (w_tx_q),
        .o_rx_q  (w_rx_q)
    );

    smt_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_res       (w_res),
        .i_tx_q      (w_tx_q),
        .i_rx_q      (w_rx_q),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_res       (w_out_res),
        .o_read_data (o_read_data)
    );

    assign o_tx_byte       = w_out_res.tx_byte;
    assign o_tx_byte_valid = w_out_res.tx_byte_valid;
    assign o_start_request = w_out_res.start_request;
    assign o_stop_request  = w_out_res.stop_request;
    assign o_ack_enable    = w_out_res.ack_enable;
    assign o_bus_busy      = w_out_res.bus_busy;
    assign o_write_done    = w_out_res.write_done;
    assign o_read_done     = w_out_res.read_done;
    assign o_no_response   = w_out_res.no_response;
    assign o_engine_reset  = w_out_res.engine_reset;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the transfer sequencer. A short table of directed
// words walks reset values, every operation and the corner cases; random
// well-formed write and read transfers with noise follow under corner and
// random configs. Results are checked by the table or an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
    import smt_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 100;
    localparam int          PIPE_LATENCY   = 4;
    localparam int          ITEM_TARGET    = 1050;
    localparam logic [2:0]  OP_SPARE       = OP_TIMEOUT + 3'd1;
    localparam logic [4:0]  ST_ARB_LOST    = 5'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] index;
        logic [7:0] data;
        logic [4:0] status;
        logic [7:0] rxb;
    } t_bus_word;

    // field order: tx_byte, tx_valid, start, stop, ack, busy, wr_done,
    // rd_done, no_resp, eng_reset, read_data
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       start_req;
        logic       stop_req;
        logic       ack_en;
        logic       busy;
        logic       wr_done;
        logic       rd_done;
        logic       no_resp;
        logic       eng_reset;
        logic [7:0] read_data;
    } t_bus_result;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  cfg_idx;
        logic [7:0]  cfg_val;
        t_bus_word   w;
        bit          typed;
        t_bus_result want;
    } t_script_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_operation;
    logic [6:0] i_buf_index;
    logic [7:0] i_buf_data;
    logic [4:0] i_status_code;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_tx_byte;
    logic       o_tx_byte_valid;
    logic       o_start_request;
    logic       o_stop_request;
    logic       o_ack_enable;
    logic       o_bus_busy;
    logic       o_write_done;
    logic       o_read_done;
    logic       o_no_response;
    logic       o_engine_reset;
    logic [7:0] o_read_data;

    smbus_master_transfer_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_buf_index     (i_buf_index),
        .i_buf_data      (i_buf_data),
        .i_status_code   (i_status_code),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tx_byte       (o_tx_byte),
        .o_tx_byte_valid (o_tx_byte_valid),
        .o_start_request (o_start_request),
        .o_stop_request  (o_stop_request),
        .o_ack_enable    (o_ack_enable),
        .o_bus_busy      (o_bus_busy),
        .o_write_done    (o_write_done),
        .o_read_done     (o_read_done),
        .o_no_response   (o_no_response),
        .o_engine_reset  (o_engine_reset),
        .o_read_data     (o_read_data)
    );

    // sequencer model state
    logic [7:0] set_target;
    logic [7:0] set_location;
    logic [7:0] set_count;
    logic       set_read;
    logic [7:0] set_retry;
    logic [7:0] tx_image [BUFFER_DEPTH];
    logic [7:0] rx_image [BUFFER_DEPTH];
    bit         rx_written [BUFFER_DEPTH];
    logic [7:0] sent_cnt;
    logic [7:0] recv_cnt;
    logic [7:0] nack_cnt;
    logic       busy_lvl;
    logic       start_lvl;
    logic       ack_lvl;
    logic [1:0] done_bits;
    logic       silent_lvl;

    t_bus_result pending_results [$];
    t_script_row script [$];
    int          mismatch_count = 0;
    int          words_offered  = 0;
    int          idle_cycles    = 0;
    bit          calm           = 1'b0;
    bit          hold_req       = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] ring_slot(logic [7:0] off);
        return ADDR_W'((int'(set_location) + int'(off)) % BUFFER_DEPTH);
    endfunction

    function automatic t_bus_result advance_sequencer(t_bus_word w);
        t_bus_result r;
        logic fail;
        logic mine;
        logic [ADDR_W-1:0] slot;
        r = '0;
        fail = 1'b0;
        mine = (set_target == SLAVE_ID);
        case (w.op)
            OP_TX_WRITE: tx_image[w.index] = w.data;
            OP_RX_READ:  r.read_data = rx_image[w.index];
            OP_BEGIN: begin
                busy_lvl = 1'b1;
                start_lvl = 1'b1;
            end
            OP_TIMEOUT: fail = 1'b1;
            OP_EVENT: begin
                case (w.status)
                    ST_START, ST_RSTART: begin
                        r.tx_byte = (set_target & DIR_MASK) | {7'b0, set_read};
                        r.tx_valid = 1'b1;
                        start_lvl = 1'b0;
                        sent_cnt = '0;
                        recv_cnt = '0;
                    end
                    ST_ADDR_ACK: if (mine) begin
                        if (set_location == PRESENCE_LOC) begin
                            r.stop_req = 1'b1;
                            busy_lvl = 1'b0;
                        end else begin
                            r.tx_byte = set_location;
                            r.tx_valid = 1'b1;
                            done_bits[0] = 1'b0;
                        end
                        silent_lvl = 1'b0;
                    end
                    ST_ADDR_NACK, ST_DATA_NACK, ST_RADDR_NACK: if (mine) begin
                        if (nack_cnt < set_retry) begin
                            nack_cnt = nack_cnt + 8'd1;
                            start_lvl = 1'b1;
                        end else begin
                            silent_lvl = 1'b1;
                            nack_cnt = '0;
                            fail = 1'b1;
                        end
                    end
                    ST_DATA_ACK: if (mine) begin
                        if (sent_cnt < set_count) begin
                            slot = ring_slot(sent_cnt);
                            r.tx_byte = tx_image[slot];
                            r.tx_valid = 1'b1;
                            sent_cnt = sent_cnt + 8'd1;
                        end else begin
                            r.stop_req = 1'b1;
                            busy_lvl = 1'b0;
                            done_bits[0] = 1'b1;
                        end
                    end
                    // ack level follows the count whoever the target is
                    ST_RADDR_ACK: ack_lvl = (set_count == 8'd1) ? 1'b0 : 1'b1;
                    ST_RDATA_ACK: if (mine) begin
                        if (recv_cnt < set_count) begin
                            slot = ring_slot(recv_cnt);
                            rx_image[slot] = w.rxb;
                            rx_written[slot] = 1'b1;
                            ack_lvl = 1'b1;
                            recv_cnt = recv_cnt + 8'd1;
                            done_bits[1] = 1'b0;
                        end else begin
                            ack_lvl = 1'b0;
                            done_bits[1] = 1'b1;
                        end
                    end
                    ST_RDATA_NACK: if (mine) begin
                        slot = ring_slot(recv_cnt);
                        rx_image[slot] = w.rxb;
                        rx_written[slot] = 1'b1;
                        r.stop_req = 1'b1;
                        busy_lvl = 1'b0;
                        ack_lvl = 1'b1;
                        done_bits[1] = 1'b1;
                    end
                    default: fail = 1'b1;
                endcase
            end
            default: ;
        endcase
        if (fail) begin
            r.eng_reset = 1'b1;
            r.stop_req = 1'b0;
            start_lvl = 1'b0;
            ack_lvl = 1'b0;
            busy_lvl = 1'b0;
            done_bits = 2'b11;
        end
        r.start_req = start_lvl;
        r.ack_en = ack_lvl;
        r.busy = busy_lvl;
        r.wr_done = done_bits[0];
        r.rd_done = done_bits[1];
        r.no_resp = silent_lvl;
        return r;
    endfunction

    function automatic t_bus_word mk_word(logic [2:0] op, logic [6:0] idx, logic [7:0] d,
                                          logic [4:0] st, logic [7:0] rxb);
        t_bus_word w;
        w.op = op;
        w.index = idx;
        w.data = d;
        w.status = st;
        w.rxb = rxb;
        return w;
    endfunction

    function automatic t_bus_word op_word(logic [2:0] op);
        return mk_word(op, 7'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    endfunction

    function automatic t_bus_word event_word(logic [4:0] st);
        t_bus_word w;
        w = op_word(OP_EVENT);
        w.status = st;
        return w;
    endfunction

    // host reads go only to rx entries that hold a received byte
    function automatic t_bus_word keep_reads_defined(t_bus_word w);
        int base;
        if (w.op != OP_RX_READ) return w;
        base = int'(w.index);
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
            if (rx_written[ADDR_W'((base + i) % BUFFER_DEPTH)]) begin
                w.index = 7'((base + i) % BUFFER_DEPTH);
                return w;
            end
        end
        w.op = OP_TX_WRITE;
        return w;
    endfunction

    function automatic t_bus_word noise_word();
        return keep_reads_defined(op_word(3'($urandom)));
    endfunction

    function automatic t_script_row plain(t_bus_word w);
        t_script_row row;
        row = '{default: '0};
        row.w = w;
        return row;
    endfunction

    function automatic t_script_row checked(t_bus_word w, t_bus_result want);
        t_script_row row;
        row = plain(w);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_script_row setting(logic [2:0] idx, logic [7:0] v);
        t_script_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = v;
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_word(t_bus_word w, bit typed, t_bus_result want);
        int gap;
        t_bus_result predicted;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_operation   <= w.op;
        i_buf_index   <= w.index;
        i_buf_data    <= w.data;
        i_status_code <= w.status;
        i_rx_byte     <= w.rxb;
        forever begin
            @(posedge i_clk);
            if (o_in_stall === 1'b0) break;
        end
        predicted = advance_sequencer(w);
        pending_results.push_back(typed ? want : predicted);
        words_offered++;
    endtask

    task automatic send_step(logic [4:0] st);
        if ($urandom_range(0, 99) < 5) offer_word(noise_word(), 1'b0, '0);
        offer_word(event_word(st), 1'b0, '0);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_TARGET:   set_target = v;
            CFG_LOCATION: set_location = v;
            CFG_COUNT:    set_count = v;
            CFG_READ:     set_read = v[0];
            CFG_RETRY:    set_retry = v;
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [7:0] tgt, logic [7:0] loc, logic [7:0] cnt,
                                logic mode, logic [7:0] rty);
        settle();
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_LOCATION, loc);
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_READ, {7'($urandom), mode});
        write_reg(CFG_RETRY, rty);
    endtask

    task automatic run_transfer();
        int r;
        int n_ack;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            offer_word(op_word(OP_BEGIN), 1'b0, '0);
            send_step(ST_START);
            if ($urandom_range(0, 4) == 0) begin
                send_step(ST_ADDR_NACK);
                send_step(ST_RSTART);
            end
            send_step(ST_ADDR_ACK);
            if (set_location != PRESENCE_LOC) begin
                if (!set_read) begin
                    // one more data ack than bytes: the last one ends it with a stop
                    for (int k = 0; k <= int'(set_count); k++) begin
                        if ($urandom_range(0, 24) == 0) send_step(ST_DATA_NACK);
                        send_step(ST_DATA_ACK);
                    end
                end else begin
                    send_step(ST_RSTART);
                    if ($urandom_range(0, 9) == 0) begin
                        send_step(ST_RADDR_NACK);
                        send_step(ST_RSTART);
                    end
                    send_step(ST_RADDR_ACK);
                    n_ack = (set_count == 8'd0) ? 1 :
                            int'(set_count) - 1 + (($urandom_range(0, 3) == 0) ? 1 : 0);
                    repeat (n_ack) send_step(ST_RDATA_ACK);
                    if (set_count != 8'd0) send_step(ST_RDATA_NACK);
                    repeat ($urandom_range(1, 3))
                        offer_word(keep_reads_defined(op_word(OP_RX_READ)), 1'b0, '0);
                end
            end
        end else if (r < 90) begin
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 1) == 0) offer_word(op_word(OP_TX_WRITE), 1'b0, '0);
                else offer_word(keep_reads_defined(op_word(OP_RX_READ)), 1'b0, '0);
            end
        end else begin
            repeat ($urandom_range(1, 4)) offer_word(noise_word(), 1'b0, '0);
        end
    endtask

    // receiver: random stalls, plus one long hold on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm) begin
                r = $urandom_range(0, 99);
                if (r >= 65) stall_left = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bus_result e;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no prediction waiting");
                mismatch_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("tx_byte", e.tx_byte, o_tx_byte);
                check_field("tx_byte_valid", 8'(e.tx_valid), 8'(o_tx_byte_valid));
                check_field("start_request", 8'(e.start_req), 8'(o_start_request));
                check_field("stop_request", 8'(e.stop_req), 8'(o_stop_request));
                check_field("ack_enable", 8'(e.ack_en), 8'(o_ack_enable));
                check_field("bus_busy", 8'(e.busy), 8'(o_bus_busy));
                check_field("write_done", 8'(e.wr_done), 8'(o_write_done));
                check_field("read_done", 8'(e.rd_done), 8'(o_read_done));
                check_field("no_response", 8'(e.no_resp), 8'(o_no_response));
                check_field("engine_reset", 8'(e.eng_reset), 8'(o_engine_reset));
                check_field("read_data", e.read_data, o_read_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** smbus_master_transfer_sequencer: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int r;
        int n_tr;
        logic [7:0] tgt;
        logic [7:0] loc;
        logic [7:0] cnt;
        logic       mode;
        logic [7:0] rty;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_operation = '0;
        i_buf_index = '0;
        i_buf_data = '0;
        i_status_code = '0;
        i_rx_byte = '0;

        set_target = 8'h20;
        set_location = '0;
        set_count = '0;
        set_read = 1'b0;
        set_retry = 8'd3;
        foreach (tx_image[i]) begin
            tx_image[i] = '0;
            rx_image[i] = '0;
            rx_written[i] = 1'b0;
        end
        sent_cnt = '0;
        recv_cnt = '0;
        nack_cnt = '0;
        busy_lvl = 1'b0;
        start_lvl = 1'b0;
        ack_lvl = 1'b1;
        done_bits = '0;
        silent_lvl = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        script.push_back(checked(mk_word(OP_SPARE, 7'h00, 8'h00, 5'h00, 8'h00),
                                 '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 8'h00}));
        script.push_back(checked(mk_word(OP_TX_WRITE, 7'h7F, 8'hFF, 5'h1F, 8'hFF),
                                 '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 8'h00}));
        script.push_back(checked(mk_word(OP_TX_WRITE, 7'h00, 8'h00, 5'h00, 8'h00),
                                 '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 8'h00}));
        script.push_back(plain(mk_word(OP_TX_WRITE, 7'h01, 8'h5A, 5'h00, 8'h00)));
        script.push_back(plain(mk_word(OP_BEGIN, 7'h00, 8'h00, 5'h00, 8'h00)));
        // begin again while the bus is claimed
        script.push_back(plain(mk_word(OP_BEGIN, 7'h00, 8'h00, 5'h00, 8'h00)));
        script.push_back(checked(mk_word(OP_EVENT, 7'h00, 8'h00, ST_START, 8'h00),
                                 '{8'h20, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                                   1'b0, 1'b0, 8'h00}));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_ADDR_ACK, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_DATA_ACK, 8'h00)));
        // write of three bytes that wraps from the top entry to the bottom
        script.push_back(setting(CFG_COUNT, 8'd3));
        script.push_back(setting(CFG_LOCATION, 8'd127));
        script.push_back(plain(mk_word(OP_BEGIN, 7'h00, 8'h00, 5'h00, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_START, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_ADDR_ACK, 8'h00)));
        repeat (4) script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_DATA_ACK, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_ADDR_NACK, 8'h00)));
        script.push_back(checked(mk_word(OP_TIMEOUT, 7'h00, 8'h00, 5'h00, 8'h00),
                                 '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                   1'b0, 1'b1, 8'h00}));
        // no retries left: the nack gives up with no response
        script.push_back(setting(CFG_RETRY, 8'd0));
        script.push_back(checked(mk_word(OP_EVENT, 7'h00, 8'h00, ST_DATA_NACK, 8'h00),
                                 '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                   1'b1, 1'b1, 8'h00}));
        script.push_back(setting(CFG_READ, 8'd1));
        script.push_back(setting(CFG_COUNT, 8'd1));
        script.push_back(setting(CFG_LOCATION, 8'd5));
        script.push_back(plain(mk_word(OP_BEGIN, 7'h00, 8'h00, 5'h00, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_START, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_ADDR_ACK, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_RSTART, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_RADDR_ACK, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_RDATA_NACK, 8'hC3)));
        script.push_back(plain(mk_word(OP_RX_READ, 7'h05, 8'h00, 5'h00, 8'h00)));
        // events for some other target are ignored, but arbitration lost still resets the engine
        script.push_back(setting(CFG_TARGET, 8'hFF));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_ADDR_ACK, 8'h00)));
        script.push_back(plain(mk_word(OP_EVENT, 7'h00, 8'h00, ST_ARB_LOST, 8'h00)));

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            end else begin
                offer_word(script[i].w, script[i].typed, script[i].want);
            end
        end

        // random part: load every tx entry first
        words_offered = 0;
        for (int i = 0; i < BUFFER_DEPTH; i++)
            offer_word(mk_word(OP_TX_WRITE, 7'(i), 8'($urandom), 5'($urandom), 8'($urandom)),
                       1'b0, '0);
        settle();

        // back-pressure: receiver holds off while words keep coming
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (40) offer_word(op_word(OP_TX_WRITE), 1'b0, '0);
        settle();
        calm = 1'b0;

        phase = 0;
        while (words_offered < ITEM_TARGET) begin
            case (phase)
                0: begin
                    tgt = SLAVE_ID; loc = 8'hFF; cnt = 8'd128; mode = 1'b0; rty = 8'hFF;
                end
                1: begin
                    tgt = SLAVE_ID; loc = 8'h00; cnt = 8'd128; mode = 1'b1; rty = 8'h00;
                end
                2: begin
                    tgt = 8'h00; loc = PRESENCE_LOC; cnt = 8'd0; mode = 1'b0; rty = 8'd1;
                end
                3: begin
                    tgt = SLAVE_ID; loc = PRESENCE_LOC; cnt = 8'd5; mode = 1'b1; rty = 8'd3;
                end
                default: begin
                    r = $urandom_range(0, 99);
                    tgt = (r < 75) ? SLAVE_ID : (r < 85) ? 8'h00 : (r < 90) ? 8'hFF
                                   : 8'($urandom);
                    r = $urandom_range(0, 99);
                    loc = (r < 10) ? PRESENCE_LOC : (r < 20) ? 8'hFF : (r < 30) ? 8'h00
                                   : 8'($urandom);
                    r = $urandom_range(0, 99);
                    cnt = (r < 70) ? 8'($urandom_range(0, 6)) :
                          (r < 97) ? 8'($urandom_range(7, 24)) : 8'd128;
                    mode = 1'($urandom_range(0, 1));
                    r = $urandom_range(0, 99);
                    rty = (r < 15) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(0, 4));
                end
            endcase
            apply_config(tgt, loc, cnt, mode, rty);
            calm = (phase % 5 == 3);
            n_tr = (cnt > 8'd24) ? 1 : $urandom_range(2, 5);
            repeat (n_tr) run_transfer();
            phase++;
        end

        settle();
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** smbus_master_transfer_sequencer: PASSED **");
        end else begin
            $display("** smbus_master_transfer_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
design/smt_pkg.sv
design/smt_buf.sv
design/smt_ctrl.sv
design/smt_pipe.sv
design/smbus_master_transfer_sequencer.sv
sim/testbench.sv
